### hw/rtl/sldpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sldpc_pkg
// Types and codes shared by the systematic block encoder modules.
// ----------------------------------------------------------------------------
package sldpc_pkg;

    localparam int ROW_W    = 32;
    localparam int IDX_W    = 5;
    localparam int LEN_W    = 6;
    localparam int CFG_IDX_W = 1;

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_MSG  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MSG_LEN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_LEN = 1'b1;

    localparam logic [LEN_W-1:0] LEN_RESET = 6'd32;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] row_index;
        logic [ROW_W-1:0] row_parity;
        logic             msg_bit;
    } t_in_item;

    typedef struct packed {
        logic             code_bit;
        logic [IDX_W-1:0] bit_position;
        logic [ROW_W-1:0] parity_word;
        logic             block_done;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic             is_load;
        logic [IDX_W-1:0] row_index;
        logic [ROW_W-1:0] row_parity;
        logic             msg_bit;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0] bit_cnt;
        logic             out_full;
    } t_back_stat;

endpackage : sldpc_pkg
`default_nettype wire

### hw/rtl/sldpc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sldpc_front
// Accepts items, drops loads aimed beyond the row store, and queues the rest
// in a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module sldpc_front
    import sldpc_pkg::*;
#(
    parameter int MAX_MSG_BITS = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_item i_req,
    output logic          o_full,
    output logic          o_cmd_valid,
    output t_cmd          o_cmd,
    input  wire logic     i_cmd_pop
);

    t_cmd        r_slot [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        n_wp, n_rp;
    logic [1:0]  n_cnt;
    logic        accept;
    logic        keep;
    t_cmd        cmd_in;

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_slot[r_rp];

    assign accept = i_push && !o_full;
    // loads past the store are swallowed here
    assign keep   = (i_req.req_type == REQ_MSG) ||
                    ({2'b00, i_req.row_index} < 7'(MAX_MSG_BITS));

    always_comb begin
        cmd_in.is_load    = (i_req.req_type == REQ_LOAD);
        cmd_in.row_index  = i_req.row_index;
        cmd_in.row_parity = i_req.row_parity;
        cmd_in.msg_bit    = i_req.msg_bit;
    end

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (accept && keep) begin
            n_wp = ~r_wp;
        end
        if (i_cmd_pop) begin
            n_rp = ~r_rp;
        end
        n_cnt = r_cnt + 2'(accept && keep) - 2'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_slot[r_wp] <= cmd_in;
        end
    end

endmodule : sldpc_front
`default_nettype wire

### hw/rtl/sldpc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sldpc_back
// Holds the row store, parity accumulator, bit counter and length registers;
// runs one item per cycle, stalling messages on a full two-entry result queue.
// ----------------------------------------------------------------------------
module sldpc_back
    import sldpc_pkg::*;
#(
    parameter int MAX_MSG_BITS    = 32,
    parameter int MAX_PARITY_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [LEN_W-1:0]     i_cfg_wdata,
    input  wire logic                 i_cmd_valid,
    input  wire t_cmd                 i_cmd,
    output logic                      o_cmd_pop,
    input  wire logic                 i_pop,
    output t_out_item                 o_rsp,
    output logic                      o_empty,
    output t_back_stat                o_stat
);

    localparam int KCAP = (MAX_MSG_BITS < 32) ? MAX_MSG_BITS : 32;
    localparam int PCAP = (MAX_PARITY_BITS < 32) ? MAX_PARITY_BITS : 32;
    localparam int ROWS = KCAP;
    localparam int RIW  = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [ROW_W-1:0] r_rows [ROWS];
    logic [ROW_W-1:0] r_acc;
    logic [IDX_W-1:0] r_bit_cnt;
    logic [LEN_W-1:0] r_msg_len, r_parity_len;

    t_out_item  r_out [2];
    logic       r_owp, r_orp;
    logic [1:0] r_ocnt;

    logic [LEN_W-1:0] klen, plen;
    logic [ROW_W-1:0] mask, row, acc_nxt;
    logic [LEN_W-1:0] pos_inc;
    logic             done;
    logic             out_full, res_push, res_pop;
    t_out_item        res;

    // effective lengths, clamped to 1..cap
    always_comb begin
        if (r_msg_len == '0) begin
            klen = LEN_W'(1);
        end else if (r_msg_len > LEN_W'(KCAP)) begin
            klen = LEN_W'(KCAP);
        end else begin
            klen = r_msg_len;
        end
        if (r_parity_len == '0) begin
            plen = LEN_W'(1);
        end else if (r_parity_len > LEN_W'(PCAP)) begin
            plen = LEN_W'(PCAP);
        end else begin
            plen = r_parity_len;
        end
    end

    assign mask = {ROW_W{1'b1}} >> (LEN_W'(ROW_W) - plen);

    // counter always stays below klen cap, so it fits the store
    assign row     = r_rows[r_bit_cnt[RIW-1:0]];
    assign acc_nxt = i_cmd.msg_bit ? (r_acc ^ row) : r_acc;
    assign pos_inc = {1'b0, r_bit_cnt} + LEN_W'(1);
    assign done    = (pos_inc >= klen);

    assign out_full  = (r_ocnt == 2'd2);
    assign o_cmd_pop = i_cmd_valid && (i_cmd.is_load || !out_full);
    assign res_push  = o_cmd_pop && !i_cmd.is_load;
    assign o_empty   = (r_ocnt == 2'd0);
    assign res_pop   = i_pop && !o_empty;
    assign o_rsp     = r_out[r_orp];

    assign o_stat.bit_cnt  = r_bit_cnt;
    assign o_stat.out_full = out_full;

    always_comb begin
        res.code_bit     = i_cmd.msg_bit;
        res.bit_position = r_bit_cnt;
        res.parity_word  = done ? (acc_nxt & mask) : '0;
        res.block_done   = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_len    <= LEN_RESET;
            r_parity_len <= LEN_RESET;
            r_acc        <= '0;
            r_bit_cnt    <= '0;
            r_owp        <= 1'b0;
            r_orp        <= 1'b0;
            r_ocnt       <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MSG_LEN:    r_msg_len    <= i_cfg_wdata;
                    CFG_PARITY_LEN: r_parity_len <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (res_push) begin
                if (done) begin
                    r_acc     <= '0;
                    r_bit_cnt <= '0;
                end else begin
                    r_acc     <= acc_nxt;
                    r_bit_cnt <= pos_inc[IDX_W-1:0];
                end
                r_owp <= ~r_owp;
            end
            if (res_pop) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + 2'(res_push) - 2'(res_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.is_load) begin
            r_rows[i_cmd.row_index[RIW-1:0]] <= i_cmd.row_parity;
        end
        if (res_push) begin
            r_out[r_owp] <= res;
        end
    end

endmodule : sldpc_back
`default_nettype wire

### hw/rtl/systematic_ldpc_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// systematic_ldpc_encoder
// Systematic binary block encoder with a loadable generator parity store.
// ----------------------------------------------------------------------------
// Takes one item per clock on push/full and hands back one result per message
// item on empty/pop. A load item writes one generator row and yields nothing;
// a message item yields its code bit, and on the last bit of a block the
// masked parity word. Results go through the front and result queue registers.
// Throughput is one item per cycle while full is low, set by the single row
// read and XOR in the back end; full rises only when two results wait unpopped.
// Loads take effect for the next message item. Rows never loaded read as
// unknown. Write msg_len and parity_len only while no items are in flight.
// ----------------------------------------------------------------------------
module systematic_ldpc_encoder
    import sldpc_pkg::*;
#(
    parameter int MAX_MSG_BITS    = 32,
    parameter int MAX_PARITY_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [LEN_W-1:0]     i_cfg_wdata,
    input  wire logic                 push,
    input  wire t_in_item             i_req,
    output logic                      full,
    output logic                      empty,
    input  wire logic                 pop,
    output t_out_item                 o_rsp
);

    logic       cmd_valid;
    logic       cmd_pop;
    t_cmd       cmd;
    t_back_stat stat;

    sldpc_front #(
        .MAX_MSG_BITS (MAX_MSG_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_req       (i_req),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    sldpc_back #(
        .MAX_MSG_BITS    (MAX_MSG_BITS),
        .MAX_PARITY_BITS (MAX_PARITY_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_rsp       (o_rsp),
        .o_empty     (empty),
        .o_stat      (stat)
    );

    // back end never takes an item the front has not queued
    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("back end popped an empty command queue");

    // a message item must not be executed into a full result queue
    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_pop && !cmd.is_load) |-> !stat.out_full)
        else $error("result queue overrun");

    // bit counter stays inside the row store
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({2'b00, stat.bit_cnt} < 7'((MAX_MSG_BITS < 32) ? MAX_MSG_BITS : 32)))
        else $error("bit counter beyond block length cap");

    // parity only shows on the last bit of a block
    a_parity_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_rsp.block_done) |-> (o_rsp.parity_word == '0))
        else $error("parity word set on a non-final bit");

endmodule : systematic_ldpc_encoder
`default_nettype wire

### verif/tb_systematic_ldpc_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_systematic_ldpc_encoder
// Self-checking bench for the systematic block encoder. A directed list of
// loads, message bits and length settings, part of it with hand-computed
// results, is followed by random row loads and message blocks under
// several lengths. Other results are checked against a local encoder model.
// Both sides idle in short random bursts, and once every eight phases the
// receiver holds off during a burst for long enough that the input stalls.
// ----------------------------------------------------------------------------
module tb_systematic_ldpc_encoder;
    import sldpc_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int SETTLE      = 4;     // cycles for a load still in the pipe
    localparam int LONG_HOLD   = 64;
    localparam int RANDOM_BODY = 1380;
    localparam int TAIL_ITEMS  = 150;
    localparam int REPORT_MAX  = 10;
    localparam int ROWS        = 32;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] sel;
        logic [LEN_W-1:0]     val;
        t_in_item             req;
        logic                 typed;
        t_out_item            want;
    } t_dir_step;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [LEN_W-1:0]     i_cfg_wdata;
    logic                 push;
    t_in_item             i_req;
    logic                 full;
    logic                 empty;
    logic                 pop;
    t_out_item            o_rsp;

    // encoder model state
    logic [ROW_W-1:0] g_rows [ROWS];
    bit   [ROWS-1:0]  row_loaded;
    logic [ROW_W-1:0] acc_parity;
    logic [IDX_W-1:0] bit_cnt;
    logic [LEN_W-1:0] k_len_reg;
    logic [LEN_W-1:0] p_len_reg;

    t_out_item rsp_due [$];
    t_dir_step dir_steps [$];

    int items_sent, loads_sent, results_checked, blocks_done;
    int reg_writes, full_stalls, holds_done, mismatches;
    bit quiet, burst_mode, hold_req;

    systematic_ldpc_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .i_req       (i_req),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_rsp       (o_rsp)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic int clip_len(input logic [LEN_W-1:0] v);
        if (v == '0) return 1;
        if (v > ROWS) return ROWS;
        return int'(v);
    endfunction

    function automatic t_out_item encode_item(input t_in_item it, output bit has_rsp);
        t_out_item        r;
        int               klen;
        int               plen;
        int               pos;
        logic [ROW_W-1:0] mask;
        r = '0;
        has_rsp = 1'b0;
        if (it.req_type == REQ_LOAD) begin
            g_rows[it.row_index] = it.row_parity;
            row_loaded[it.row_index] = 1'b1;
            return r;
        end
        klen = clip_len(k_len_reg);
        plen = clip_len(p_len_reg);
        mask = {ROW_W{1'b1}} >> (ROW_W - plen);
        pos = int'(bit_cnt);
        if (it.msg_bit) acc_parity ^= g_rows[pos];
        r.code_bit = it.msg_bit;
        r.bit_position = bit_cnt;
        has_rsp = 1'b1;
        // a counter already at or past a shortened length ends the block here
        if (pos + 1 >= klen) begin
            r.parity_word = acc_parity & mask;
            r.block_done = 1'b1;
            acc_parity = '0;
            bit_cnt = '0;
            blocks_done++;
        end else begin
            bit_cnt = bit_cnt + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] random_len();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 6'd1;
            2: return 6'd32;
            3: return LEN_W'($urandom_range(33, 63));
            4, 5: return LEN_W'($urandom_range(2, 8));
            default: return LEN_W'($urandom_range(1, 31));
        endcase
    endfunction

    function automatic t_in_item make_load(input logic [IDX_W-1:0] idx);
        t_in_item it;
        it.req_type = REQ_LOAD;
        it.row_index = idx;
        case ($urandom_range(0, 9))
            0: it.row_parity = '0;
            1: it.row_parity = '1;
            default: it.row_parity = $urandom;
        endcase
        it.msg_bit = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_in_item make_msg();
        t_in_item it;
        it.req_type = REQ_MSG;
        it.row_index = IDX_W'($urandom);
        it.row_parity = $urandom;
        it.msg_bit = 1'($urandom_range(0, 1));
        // a 1 on a never-loaded row is outside the contract
        if (!row_loaded[bit_cnt]) it.msg_bit = 1'b0;
        return it;
    endfunction

    function automatic t_in_item random_item();
        if ($urandom_range(0, 7) == 0) return make_load(IDX_W'($urandom_range(0, ROWS - 1)));
        return make_msg();
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] sel,
                                    input logic [LEN_W-1:0] val);
        t_dir_step s;
        s = '0;
        s.is_cfg = 1'b1;
        s.sel = sel;
        s.val = val;
        dir_steps = {dir_steps, s};
    endfunction

    function automatic void add_load(input logic [IDX_W-1:0] idx,
                                     input logic [ROW_W-1:0] par);
        t_dir_step s;
        s = '0;
        s.req.req_type = REQ_LOAD;
        s.req.row_index = idx;
        s.req.row_parity = par;
        s.req.msg_bit = 1'b1;
        dir_steps = {dir_steps, s};
    endfunction

    function automatic void add_msg(input logic b, input bit typed = 1'b0,
                                    input logic [IDX_W-1:0] pos = '0,
                                    input logic [ROW_W-1:0] par = '0,
                                    input logic done = 1'b0);
        t_dir_step s;
        s = '0;
        s.req.req_type = REQ_MSG;
        s.req.row_index = IDX_W'($urandom);
        s.req.row_parity = $urandom;
        s.req.msg_bit = b;
        s.typed = typed;
        s.want.code_bit = b;
        s.want.bit_position = pos;
        s.want.parity_word = par;
        s.want.block_done = done;
        dir_steps = {dir_steps, s};
    endfunction

    task automatic flag_mismatch(input string what, input t_out_item want,
                                 input t_out_item got);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("%0t %s: expected bit %0b pos %0d parity %h done %0b,",
                     $time, what, want.code_bit, want.bit_position, want.parity_word,
                     want.block_done);
            $display("    got bit %0b pos %0d parity %h done %0b",
                     got.code_bit, got.bit_position, got.parity_word, got.block_done);
        end
    endtask

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        int        gap;
        bit        has_rsp;
        t_out_item pred;
        gap = 0;
        if (!quiet && !burst_mode && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 5);
        @(negedge i_clk);
        if (gap != 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push = 1'b1;
        i_req = it;
        @(posedge i_clk);
        while (full) begin
            full_stalls++;
            @(posedge i_clk);
        end
        pred = encode_item(it, has_rsp);
        items_sent++;
        if (it.req_type == REQ_LOAD) loads_sent++;
        if (has_rsp) rsp_due = {rsp_due, (typed ? want : pred)};
    endtask

    // stop sending and wait until every expected result has come out
    task automatic drain();
        @(negedge i_clk);
        push = 1'b0;
        while (rsp_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [LEN_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = sel;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (sel == CFG_MSG_LEN) k_len_reg = val;
        else if (sel == CFG_PARITY_LEN) p_len_reg = val;
        reg_writes++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (rsp_due.size() == 0) begin
                flag_mismatch("result with nothing expected", '0, o_rsp);
            end else begin
                want = rsp_due.pop_front();
                results_checked++;
                if (o_rsp.code_bit !== want.code_bit ||
                    o_rsp.bit_position !== want.bit_position ||
                    o_rsp.parity_word !== want.parity_word ||
                    o_rsp.block_done !== want.block_done)
                    flag_mismatch("result mismatch", want, o_rsp);
            end
        end
    end

    // receiver: short random stalls, plus a long hold-off on request
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                pop = 1'b0;
                holds_done++;
                for (int c = 1; c < LONG_HOLD; c++) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                pop = 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge i_clk);
            end else begin
                pop = 1'b1;
            end
        end
    end

    initial begin
        #(4_000_000);
        $display("== FAIL ==");
        $display("timeout with %0d results still due", rsp_due.size());
        $finish;
    end

    initial begin
        int n;
        int wk;
        int phase;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        push = 1'b0;
        i_req = '0;
        acc_parity = '0;
        bit_cnt = '0;
        k_len_reg = LEN_RESET;
        p_len_reg = LEN_RESET;
        row_loaded = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero lengths clip to one, oversize to 32
        add_cfg(CFG_MSG_LEN, 6'd0);
        add_cfg(CFG_PARITY_LEN, 6'd0);
        add_load(5'd0, 32'hFFFF_FFFF);
        add_msg(1'b1, 1'b1, 5'd0, 32'h0000_0001, 1'b1);
        add_msg(1'b0, 1'b1, 5'd0, 32'h0, 1'b1);
        add_cfg(CFG_PARITY_LEN, 6'd63);
        add_msg(1'b1, 1'b1, 5'd0, 32'hFFFF_FFFF, 1'b1);
        add_cfg(CFG_MSG_LEN, 6'd63);
        add_load(5'd31, 32'h8000_0001);
        add_load(5'd1, 32'h0);
        add_msg(1'b1, 1'b1, 5'd0, 32'h0, 1'b0);
        add_msg(1'b1, 1'b1, 5'd1, 32'h0, 1'b0);
        // shorten the block below the count reached: next bit closes it
        add_cfg(CFG_MSG_LEN, 6'd2);
        add_msg(1'b0, 1'b1, 5'd2, 32'hFFFF_FFFF, 1'b1);
        add_msg(1'b1, 1'b1, 5'd0, 32'h0, 1'b0);
        // row rewritten inside a block is used at once
        add_load(5'd1, 32'h0000_FFFF);
        add_msg(1'b1, 1'b1, 5'd1, 32'hFFFF_0000, 1'b1);
        add_cfg(CFG_PARITY_LEN, 6'd20);
        add_msg(1'b1, 1'b1, 5'd0, 32'h0, 1'b0);
        add_msg(1'b1, 1'b1, 5'd1, 32'h000F_0000, 1'b1);
        add_cfg(CFG_MSG_LEN, 6'd33);
        add_load(5'd2, 32'h5A5A_5A5A);
        add_msg(1'b1);
        add_msg(1'b0);
        add_msg(1'b1);

        foreach (dir_steps[i]) begin
            if (dir_steps[i].is_cfg) begin
                drain();
                write_reg(dir_steps[i].sel, dir_steps[i].val);
            end else begin
                send_item(dir_steps[i].req, dir_steps[i].typed, dir_steps[i].want);
            end
        end

        // fill the row store so any later message bit is legal
        for (int r = 0; r < ROWS; r++) send_item(make_load(IDX_W'(r)), 1'b0, '0);

        phase = 0;
        while (items_sent < RANDOM_BODY) begin
            drain();
            wk = $urandom_range(0, 2);
            if (wk != 1) write_reg(CFG_MSG_LEN, random_len());
            if (wk != 0) write_reg(CFG_PARITY_LEN, random_len());
            burst_mode = (phase % 8 == 3);
            if (burst_mode) hold_req = 1'b1;
            n = burst_mode ? 40 : $urandom_range(15, 70);
            repeat (n) send_item(random_item(), 1'b0, '0);
            burst_mode = 1'b0;
            phase++;
        end

        // closing stretch at full rate on both sides
        drain();
        quiet = 1'b1;
        write_reg(CFG_MSG_LEN, 6'd32);
        write_reg(CFG_PARITY_LEN, random_len());
        repeat (TAIL_ITEMS) send_item(random_item(), 1'b0, '0);
        drain();

        mismatches += rsp_due.size();
        $display("%0d items sent (%0d row loads), %0d register writes, %0d long receiver holds",
                 items_sent, loads_sent, reg_writes, holds_done);
        $display("%0d results checked over %0d finished blocks, input stalled %0d cycles",
                 results_checked, blocks_done, full_stalls);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
